[hdl/wrp_pkg.sv]
// Package for the WAV/RIFF header parser.
// Holds the word types, phase and code enums, and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package wrp_pkg;

  localparam int unsigned QuoW  = 31;
  localparam int unsigned DivW  = 16;
  localparam logic [3:0]  RiffLastIdx = 4'd11;
  localparam logic [31:0] FmtLen      = 32'd16;
  localparam logic signed [15:0] MinBits = 16'sd8;
  localparam logic [31:0] IdFmt  = 32'h2074_6D66;
  localparam logic [31:0] IdData = 32'h6174_6164;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RIFF,
    PH_HDR,
    PH_SKIP,
    PH_FMT,
    PH_DIVA,
    PH_DIVB,
    PH_DIVC,
    PH_EMIT,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_DATA,
    KIND_ERR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NO_FMT,
    ERR_NO_DATA,
    ERR_NEG_LEN,
    ERR_LOW_BITS,
    ERR_NO_CHAN
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_word_t;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   sample_byte;
    logic [15:0]  channel_count;
    logic [31:0]  sample_rate;
    logic [12:0]  bytes_per_sample;
    logic [30:0]  data_size;
    logic [30:0]  frame_count;
    err_e         error_code;
    logic         last;
  } out_word_t;

  typedef struct packed {
    logic  clr_start;
    logic  riff_inc;
    logic  hdr_enter;
    logic  hdr_byte;
    logic  fmt_enter;
    logic  fmt_byte;
    logic  skip_load;
    logic  skip_dec;
    logic  data_load;
    logic  data_dec;
    logic  div_start;
    logic  div_sel;
    logic  emit;
    kind_e emit_kind;
    err_e  emit_err;
    logic  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic riff_done;
    logic hdr_last;
    logic len_neg;
    logic len_zero;
    logic id_fmt;
    logic id_data;
    logic fmt_seen;
    logic chan_zero;
    logic skip_last;
    logic skip_zero;
    logic fmt_last;
    logic bits_low;
    logic data_last;
    logic width_zero;
    logic div_done;
  } dp_sts_t;

endpackage

[hdl/wrp_if.sv]
// Handshake channels of the WAV/RIFF header parser: input bytes and results.
// Depends on wrp_pkg.
`timescale 1ns / 1ps

interface wrp_in_if import wrp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wrp_out_if import wrp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/wrp_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wrp_pkg.
`timescale 1ns / 1ps

module wrp_div import wrp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QuoW-1:0]   dividend_i,
  input  logic [DivW-1:0]   divisor_i,
  output logic              done_o,
  output logic [QuoW-1:0]   quotient_o
);

  localparam int unsigned CntW = $clog2(QuoW);
  localparam logic [CntW-1:0] LastStep = CntW'(QuoW - 1);

  logic              run_q, run_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]   dsr_q, dsr_d;
  logic [DivW:0]     trial;
  logic              fits;

  assign trial = {rem_q, quo_q[QuoW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[QuoW-2:0], fits};
      rem_d = fits ? DivW'(trial - {1'b0, dsr_q}) : trial[DivW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hdl/wrp_datapath.sv]
// Datapath of the parser: byte counter, chunk id and length assembly,
// format fields, skip and data counters, divider and result register.
// Depends on wrp_pkg and wrp_div.
`timescale 1ns / 1ps

module wrp_datapath import wrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_ready_i,
  output dp_sts_t    sts_o,
  output logic       out_valid_o,
  output out_word_t  out_word_o
);

  logic [3:0]  cnt_q;
  logic [31:0] id_q;
  logic [23:0] asm_q;
  logic        seen_q;
  logic [15:0] chan_q;
  logic [31:0] rate_q;
  logic [15:0] bits_q;
  logic [31:0] skip_q;
  logic [30:0] rem_q;
  logic        out_valid_q;
  out_word_t   out_q, out_d;

  logic [31:0]     len_full;
  logic [12:0]     width;
  logic [QuoW-1:0] div_a;
  logic [DivW-1:0] div_b;
  logic            div_done;
  logic [QuoW-1:0] div_quo;
  logic [2:0]      hk;

  assign len_full = {data_byte_i, asm_q};
  assign width    = bits_q[15:3];
  assign hk       = cnt_q[2:0];

  assign div_a = cmd_i.div_sel ? div_quo : QuoW'(rem_q);
  assign div_b = cmd_i.div_sel ? chan_q : DivW'(width);

  wrp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.riff_done  = cnt_q == RiffLastIdx;
    sts_o.hdr_last   = hk == 3'd7;
    sts_o.len_neg    = len_full[31];
    sts_o.len_zero   = len_full == '0;
    sts_o.id_fmt     = id_q == IdFmt;
    sts_o.id_data    = id_q == IdData;
    sts_o.fmt_seen   = seen_q;
    sts_o.chan_zero  = chan_q == '0;
    sts_o.skip_last  = skip_q <= 32'd1;
    sts_o.skip_zero  = skip_q == '0;
    sts_o.fmt_last   = cnt_q == 4'd15;
    sts_o.bits_low   = $signed({data_byte_i, bits_q[7:0]}) < MinBits;
    sts_o.data_last  = rem_q <= 31'd1;
    sts_o.width_zero = width == '0;
    sts_o.div_done   = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        cnt_q <= 4'd1;
      end else if (cmd_i.hdr_enter || cmd_i.fmt_enter) begin
        cnt_q <= '0;
      end else if (cmd_i.hdr_byte) begin
        cnt_q <= {1'b0, hk} + 4'd1;
      end else if (cmd_i.riff_inc || cmd_i.fmt_byte) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clr_start) begin
        seen_q <= 1'b0;
      end else if (cmd_i.fmt_enter) begin
        seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_byte) begin
      unique case (hk)
        3'd0: id_q[7:0]    <= data_byte_i;
        3'd1: id_q[15:8]   <= data_byte_i;
        3'd2: id_q[23:16]  <= data_byte_i;
        3'd3: id_q[31:24]  <= data_byte_i;
        3'd4: asm_q[7:0]   <= data_byte_i;
        3'd5: asm_q[15:8]  <= data_byte_i;
        3'd6: asm_q[23:16] <= data_byte_i;
        default: ;
      endcase
    end
    if (cmd_i.hdr_enter) begin
      id_q  <= '0;
      asm_q <= '0;
    end
    if (cmd_i.fmt_byte) begin
      unique case (cnt_q)
        4'd2:  chan_q[7:0]   <= data_byte_i;
        4'd3:  chan_q[15:8]  <= data_byte_i;
        4'd4:  rate_q[7:0]   <= data_byte_i;
        4'd5:  rate_q[15:8]  <= data_byte_i;
        4'd6:  rate_q[23:16] <= data_byte_i;
        4'd7:  rate_q[31:24] <= data_byte_i;
        4'd14: bits_q[7:0]   <= data_byte_i;
        4'd15: bits_q[15:8]  <= data_byte_i;
        default: ;
      endcase
    end
    if (cmd_i.clr_start || cmd_i.fmt_enter) begin
      chan_q <= '0;
      rate_q <= '0;
      bits_q <= '0;
    end
    if (cmd_i.fmt_enter) begin
      skip_q <= (len_full > FmtLen) ? len_full - FmtLen : '0;
    end else if (cmd_i.skip_load) begin
      skip_q <= len_full + {31'd0, len_full[0]};
    end else if (cmd_i.skip_dec && skip_q != '0) begin
      skip_q <= skip_q - 32'd1;
    end
    if (cmd_i.data_load) begin
      rem_q <= len_full[30:0];
    end else if (cmd_i.data_dec && rem_q != '0) begin
      rem_q <= rem_q - 31'd1;
    end
  end

  always_comb begin
    out_d = '0;
    out_d.kind = cmd_i.emit_kind;
    out_d.last = cmd_i.emit_last;
    unique case (cmd_i.emit_kind)
      KIND_HDR: begin
        out_d.channel_count    = chan_q;
        out_d.sample_rate      = rate_q;
        out_d.bytes_per_sample = width;
        out_d.data_size        = rem_q;
        out_d.frame_count      = (width == '0) ? '0 : div_quo;
      end
      KIND_DATA: out_d.sample_byte = data_byte_i;
      KIND_ERR:  out_d.error_code  = cmd_i.emit_err;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[hdl/wrp_ctrl.sv]
// Parser controller: phase state machine that walks the RIFF chunks,
// sequences the frame-count division and decides each result.
// Depends on wrp_pkg.
`timescale 1ns / 1ps

module wrp_ctrl import wrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    file_start_i,
  input  logic    file_end_i,
  input  dp_sts_t sts_i,
  output logic    in_ready_o,
  output dp_cmd_t cmd_o
);

  phase_e phase_q, phase_d;
  logic   fin_q, fin_d;
  phase_e cur;
  logic   acc;
  logic   seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    unique case (phase_q)
      PH_DIVA, PH_DIVB, PH_DIVC, PH_EMIT: in_ready_o = 1'b0;
      default:                            in_ready_o = sts_i.out_free;
    endcase
    acc     = in_valid_i && in_ready_o;
    cur     = (acc && file_start_i) ? PH_RIFF : phase_q;
    seen    = sts_i.fmt_seen && !(acc && file_start_i);
    phase_d = phase_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.clr_start = acc && file_start_i;

    unique case (cur)
      PH_RIFF: begin
        if (acc && !file_start_i) begin
          cmd_o.riff_inc = 1'b1;
          if (sts_i.riff_done) begin
            cmd_o.hdr_enter = 1'b1;
            phase_d = PH_HDR;
          end else begin
            phase_d = PH_RIFF;
          end
        end else if (acc) begin
          phase_d = PH_RIFF;
        end
      end
      PH_HDR: begin
        if (acc) begin
          cmd_o.hdr_byte = 1'b1;
          if (sts_i.hdr_last) begin
            if (sts_i.len_neg) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_ERR;
              cmd_o.emit_err  = ERR_NEG_LEN;
            end else if (!seen && sts_i.id_fmt) begin
              cmd_o.fmt_enter = 1'b1;
              phase_d = PH_FMT;
            end else if (seen && sts_i.id_data) begin
              if (sts_i.chan_zero) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_ERR;
                cmd_o.emit_err  = ERR_NO_CHAN;
              end else begin
                cmd_o.data_load = 1'b1;
                fin_d   = sts_i.len_zero || file_end_i;
                phase_d = PH_DIVA;
              end
            end else if (sts_i.len_zero) begin
              cmd_o.hdr_enter = 1'b1;
            end else begin
              cmd_o.skip_load = 1'b1;
              phase_d = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (acc) begin
          cmd_o.skip_dec = 1'b1;
          if (sts_i.skip_last) begin
            cmd_o.hdr_enter = 1'b1;
            phase_d = PH_HDR;
          end
        end
      end
      PH_FMT: begin
        if (acc) begin
          cmd_o.fmt_byte = 1'b1;
          if (sts_i.fmt_last) begin
            if (sts_i.bits_low) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_ERR;
              cmd_o.emit_err  = ERR_LOW_BITS;
            end else if (sts_i.skip_zero) begin
              cmd_o.hdr_enter = 1'b1;
              phase_d = PH_HDR;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
      end
      PH_DIVA: begin
        if (sts_i.width_zero) begin
          phase_d = PH_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          phase_d = PH_DIVB;
        end
      end
      PH_DIVB: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          phase_d = PH_DIVC;
        end
      end
      PH_DIVC: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          phase_d = PH_EMIT;
        end
      end
      PH_EMIT: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_HDR;
          cmd_o.emit_last = fin_q;
          phase_d = fin_q ? PH_DONE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (acc) begin
          cmd_o.data_dec  = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_DATA;
          cmd_o.emit_last = sts_i.data_last || file_end_i;
          if (cmd_o.emit_last) begin
            phase_d = PH_DONE;
          end
        end
      end
      default: ;
    endcase

    if (cmd_o.emit && cmd_o.emit_kind == KIND_ERR) begin
      cmd_o.emit_last = 1'b1;
      phase_d = PH_DONE;
    end

    if (acc && file_end_i && !cmd_o.emit && (phase_d == PH_RIFF || phase_d == PH_HDR ||
        phase_d == PH_SKIP || phase_d == PH_FMT)) begin
      cmd_o.emit      = 1'b1;
      cmd_o.emit_kind = KIND_ERR;
      cmd_o.emit_err  = (seen || cmd_o.fmt_enter) ? ERR_NO_DATA : ERR_NO_FMT;
      cmd_o.emit_last = 1'b1;
      phase_d = PH_DONE;
    end
  end

endmodule

[hdl/wav_riff_header_parser_core.sv]
// Top level of the WAV/RIFF header parser: controller plus datapath.
// Depends on wrp_pkg, wrp_if, wrp_ctrl and wrp_datapath.
//
//   channel     dir   word        fields
//   data_in_i   sink  in_word_t   data_byte, file_start, file_end
//   result_o    src   out_word_t  kind, sample_byte, header fields, error_code, last
//
// One byte per cycle while walking chunks and passing data through, while the result register is free.
// Once the data chunk is found, input stalls while two 31-step radix-2
// divisions on the shared serial divider give the frame count (skipped when bytes_per_sample is zero).
// A single result register sits on the output; a held result blocks new bytes.
// rst_ni clears the phase to idle; nothing happens until a file_start byte.
`timescale 1ns / 1ps

module wav_riff_header_parser_core import wrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wrp_in_if.sink    data_in_i,
  wrp_out_if.source result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  wrp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (data_in_i.valid),
    .file_start_i (data_in_i.payload.file_start),
    .file_end_i   (data_in_i.payload.file_end),
    .sts_i        (sts),
    .in_ready_o   (data_in_i.ready),
    .cmd_o        (cmd)
  );

  wrp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (data_in_i.payload.data_byte),
    .out_ready_i (result_o.ready),
    .sts_o       (sts),
    .out_valid_o (result_o.valid),
    .out_word_o  (result_o.payload)
  );

endmodule

[hdl/wrp_checker.sv]
// Port-level checks on the parser results, bound to the top level.
// Depends on wrp_pkg and wav_riff_header_parser_core.
`timescale 1ns / 1ps

module wrp_checker import wrp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_word_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result dropped or changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.kind == KIND_ERR |-> out_word_i.last)
    else $error("error result without last");

  a_hdr_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.kind == KIND_HDR |->
      out_word_i.frame_count <= out_word_i.data_size && out_word_i.channel_count != '0)
    else $error("header result inconsistent");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.kind == KIND_DATA |->
      out_word_i.channel_count == '0 && out_word_i.frame_count == '0 &&
      out_word_i.error_code == ERR_NO_FMT)
    else $error("data result carries header fields");

endmodule

bind wav_riff_header_parser_core wrp_checker u_wrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_word_i  (result_o.payload)
);

[bench/tb.sv]
// Testbench for wav_riff_header_parser_core: feeds whole WAV files byte by byte
// and checks every result word against a byte-level parser model kept here.
// Depends on wrp_pkg, wrp_if and the parser RTL.
`timescale 1ns / 1ps

module tb;
  import wrp_pkg::*;

  localparam int BodyCap = 40;

  typedef enum {WANT_MODEL, WANT_CODE, WANT_QUIET} want_e;

  typedef struct {
    bit        no_start;
    bit        has_pre;
    bit [31:0] pre_id;
    bit [31:0] pre_len;
    bit [31:0] fmt_id;
    bit [31:0] fmt_len;
    bit [15:0] chans;
    bit [31:0] rate;
    bit [15:0] bits;
    bit        has_mid;
    bit [31:0] mid_len;
    bit [31:0] data_id;
    bit [31:0] data_len;
    int        extra;
    int        cut_at;
    bit        end_flag;
    want_e     want;
    err_e      want_err;
  } wav_plan_t;

  logic clk_i;
  logic rst_ni;

  wrp_in_if  in_ch ();
  wrp_out_if res_ch ();

  wav_riff_header_parser_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_in_i (in_ch),
    .result_o  (res_ch)
  );

  // parser state
  phase_e      walk;
  logic [31:0] cnt;
  logic [31:0] len_acc;
  logic [31:0] id_acc;
  logic        fmt_seen;
  logic [15:0] chans_h;
  logic [31:0] rate_h;
  logic [15:0] bits_h;
  logic [31:0] skip_left;
  logic [30:0] data_left;

  out_word_t   pending_results[$];
  logic [7:0]  wav_bytes[$];
  bit          cut_short;
  int          fault_count = 0;
  int          items_sent = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asks = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void parser_clear();
    walk      = PH_IDLE;
    cnt       = '0;
    len_acc   = '0;
    id_acc    = '0;
    fmt_seen  = 1'b0;
    chans_h   = '0;
    rate_h    = '0;
    bits_h    = '0;
    skip_left = '0;
    data_left = '0;
  endfunction

  function automatic void open_chunk();
    walk    = PH_HDR;
    cnt     = '0;
    id_acc  = '0;
    len_acc = '0;
  endfunction

  function automatic out_word_t error_word(input err_e code);
    out_word_t r;
    r            = '0;
    r.kind       = KIND_ERR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic bit predict_parse(input in_word_t w, output out_word_t r);
    logic [31:0] len;
    logic [31:0] frames;
    logic [12:0] width;
    int          k;
    bit          got;
    got = 1'b0;
    r   = '0;
    if (w.file_start) begin
      parser_clear();
      walk = PH_RIFF;
    end
    case (walk)
      PH_RIFF: begin
        cnt++;
        if (cnt >= 32'd12) open_chunk();
      end
      PH_HDR: begin
        k = int'(cnt[2:0]);
        if (k < 4) id_acc |= 32'(w.data_byte) << (8 * k);
        else len_acc |= 32'(w.data_byte) << (8 * (k - 4));
        cnt = 32'(k + 1);
        if (cnt == 32'd8) begin
          len = len_acc;
          if (len[31]) begin
            r    = error_word(ERR_NEG_LEN);
            walk = PH_DONE;
            got  = 1'b1;
          end else if (!fmt_seen && id_acc == IdFmt) begin
            fmt_seen  = 1'b1;
            skip_left = (len > FmtLen) ? len - FmtLen : '0;
            chans_h   = '0;
            rate_h    = '0;
            bits_h    = '0;
            walk      = PH_FMT;
            cnt       = '0;
          end else if (fmt_seen && id_acc == IdData) begin
            got = 1'b1;
            if (chans_h == 0) begin
              r    = error_word(ERR_NO_CHAN);
              walk = PH_DONE;
            end else begin
              width  = 13'(bits_h / 16'd8);
              frames = (width != 0) ? (len / 32'(width)) / 32'(chans_h) : '0;
              r.kind             = KIND_HDR;
              r.channel_count    = chans_h;
              r.sample_rate      = rate_h;
              r.bytes_per_sample = width;
              r.data_size        = len[30:0];
              r.frame_count      = frames[30:0];
              r.last             = (len == 0) || w.file_end;
              data_left          = len[30:0];
              walk               = r.last ? PH_DONE : PH_DATA;
            end
          end else begin
            skip_left = len + {31'd0, len[0]};
            if (skip_left != 0) walk = PH_SKIP;
            else open_chunk();
          end
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) open_chunk();
      end
      PH_FMT: begin
        k = int'(cnt[3:0]);
        if (k == 2 || k == 3) chans_h |= 16'(w.data_byte) << (8 * (k - 2));
        else if (k >= 4 && k <= 7) rate_h |= 32'(w.data_byte) << (8 * (k - 4));
        else if (k == 14 || k == 15) bits_h |= 16'(w.data_byte) << (8 * (k - 14));
        cnt = 32'(k + 1);
        if (cnt == FmtLen) begin
          if ($signed(bits_h) < MinBits) begin
            r    = error_word(ERR_LOW_BITS);
            walk = PH_DONE;
            got  = 1'b1;
          end else if (skip_left != 0) begin
            walk = PH_SKIP;
          end else begin
            open_chunk();
          end
        end
      end
      PH_DATA: begin
        if (data_left != 0) data_left--;
        r.kind        = KIND_DATA;
        r.sample_byte = w.data_byte;
        r.last        = (data_left == 0) || w.file_end;
        if (r.last) walk = PH_DONE;
        got = 1'b1;
      end
      default: ;
    endcase
    if (!got && w.file_end && walk >= PH_RIFF && walk <= PH_FMT) begin
      r    = error_word(fmt_seen ? ERR_NO_DATA : ERR_NO_FMT);
      walk = PH_DONE;
      got  = 1'b1;
    end
    return got;
  endfunction

  task automatic send_byte(input in_word_t w, input want_e mode, input err_e code);
    out_word_t r;
    bit        got;
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    got = predict_parse(w, r);
    if (mode == WANT_QUIET) got = 1'b0;
    else if (mode == WANT_CODE && got && r.kind == KIND_ERR) r = error_word(code);
    if (got) pending_results.push_back(r);
  endtask

  task automatic put_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_body(input logic [31:0] len, input bit pad);
    int n;
    if (len > BodyCap) begin
      n         = $urandom_range(1, 6);
      cut_short = 1'b1;
    end else begin
      n = int'(len) + int'(pad && len[0]);
    end
    repeat (n) wav_bytes.push_back(8'($urandom()));
  endtask

  task automatic play_file(input wav_plan_t p);
    in_word_t   w;
    logic [7:0] b;
    int         last;
    wav_bytes.delete();
    cut_short = 1'b0;
    repeat (12) wav_bytes.push_back(8'($urandom()));
    if (p.has_pre) begin
      put_word(p.pre_id);
      put_word(p.pre_len);
      put_body(p.pre_len, 1'b1);
    end
    if (!cut_short) begin
      put_word(p.fmt_id);
      put_word(p.fmt_len);
      if (p.fmt_len > BodyCap) begin
        put_body(p.fmt_len, 1'b0);
      end else begin
        for (int i = 0; i < int'(p.fmt_len); i++) begin
          case (i)
            2, 3:             b = p.chans[8*(i-2) +: 8];
            4, 5, 6, 7:       b = p.rate[8*(i-4) +: 8];
            14, 15:           b = p.bits[8*(i-14) +: 8];
            default:          b = 8'($urandom());
          endcase
          wav_bytes.push_back(b);
        end
      end
    end
    if (!cut_short && p.has_mid) begin
      put_word($urandom());
      put_word(p.mid_len);
      put_body(p.mid_len, 1'b1);
    end
    if (!cut_short) begin
      put_word(p.data_id);
      put_word(p.data_len);
      put_body(p.data_len, 1'b0);
      if (!cut_short) repeat (p.extra) wav_bytes.push_back(8'($urandom()));
    end
    last = (p.cut_at >= 0 && p.cut_at < wav_bytes.size()) ? p.cut_at : wav_bytes.size() - 1;
    for (int i = 0; i <= last; i++) begin
      w.data_byte  = wav_bytes[i];
      w.file_start = (i == 0) && !p.no_start;
      w.file_end   = (i == last) && p.end_flag;
      send_byte(w, p.want, p.want_err);
    end
  endtask

  function automatic wav_plan_t plain_file();
    wav_plan_t p;
    p.no_start = 1'b0;
    p.has_pre  = 1'b0;
    p.pre_id   = 32'h5453_494C;
    p.pre_len  = 32'd4;
    p.fmt_id   = IdFmt;
    p.fmt_len  = FmtLen;
    p.chans    = 16'd2;
    p.rate     = 32'd48000;
    p.bits     = 16'd16;
    p.has_mid  = 1'b0;
    p.mid_len  = 32'd2;
    p.data_id  = IdData;
    p.data_len = 32'd8;
    p.extra    = 0;
    p.cut_at   = -1;
    p.end_flag = 1'b1;
    p.want     = WANT_MODEL;
    p.want_err = ERR_NO_FMT;
    return p;
  endfunction

  function automatic wav_plan_t random_file();
    wav_plan_t p;
    p          = plain_file();
    p.no_start = ($urandom_range(0, 19) == 0);
    p.has_pre  = ($urandom_range(0, 3) == 0);
    p.pre_id   = ($urandom_range(0, 3) == 0) ? IdData : $urandom();
    p.pre_len  = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 9);
    p.fmt_id   = ($urandom_range(0, 11) == 0) ? $urandom() : IdFmt;
    case ($urandom_range(0, 19))
      0:          p.fmt_len = $urandom();
      1:          p.fmt_len = $urandom_range(0, 15);
      2, 3, 4, 5: p.fmt_len = $urandom_range(17, 26);
      default:    p.fmt_len = FmtLen;
    endcase
    case ($urandom_range(0, 24))
      0:       p.chans = '0;
      1, 2:    p.chans = 16'($urandom());
      default: p.chans = 16'($urandom_range(1, 8));
    endcase
    p.rate = $urandom();
    case ($urandom_range(0, 9))
      0:       p.bits = 16'($urandom());
      1:       p.bits = 16'($urandom_range(0, 40));
      default: p.bits = 16'(8 * $urandom_range(1, 4));
    endcase
    p.has_mid  = ($urandom_range(0, 4) == 0);
    p.mid_len  = $urandom_range(0, 7);
    p.data_id  = ($urandom_range(0, 15) == 0) ? $urandom() : IdData;
    p.data_len = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 24);
    p.extra    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    case ($urandom_range(0, 19))
      0, 1: p.cut_at = $urandom_range(0, 60);
      2: begin
        p.cut_at   = $urandom_range(0, 60);
        p.end_flag = 1'b0;
      end
      3:       p.end_flag = 1'b0;
      default: ;
    endcase
    return p;
  endfunction

  task automatic set_idling(input int m);
    case (m)
      0: begin
        send_gap_pct = 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_gap_pct = 64;
        recv_stall_pct <= 0;
      end
      2: begin
        send_gap_pct = 0;
        recv_stall_pct <= 64;
      end
      default: begin
        send_gap_pct = 27;
        recv_stall_pct <= 27;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result expected none, got kind %0d byte %0h last %0b",
               $time, got.kind, got.sample_byte, got.last);
      fault_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("sample_byte", want.sample_byte, got.sample_byte);
      compare_field("channel_count", want.channel_count, got.channel_count);
      compare_field("sample_rate", want.sample_rate, got.sample_rate);
      compare_field("bytes_per_sample", want.bytes_per_sample, got.bytes_per_sample);
      compare_field("data_size", want.data_size, got.data_size);
      compare_field("frame_count", want.frame_count, got.frame_count);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("last", want.last, got.last);
    end
  endtask

  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) check_result(res_ch.payload);
      if (hold_left == 0 && hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    wav_plan_t script[$];
    wav_plan_t p;
    in_word_t  w;
    int        file_idx;
    int        drain;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    parser_clear();

    // bytes before any file start
    p = plain_file(); p.no_start = 1'b1; p.want = WANT_QUIET; script.push_back(p);
    p = plain_file(); script.push_back(p);
    p = plain_file(); p.chans = 16'hFFFF; p.rate = 32'hFFFF_FFFF; p.bits = 16'h7FFF;
    p.data_len = 32'h7FFF_FFFF; script.push_back(p);
    p = plain_file(); p.chans = 16'd1; p.rate = '0; p.bits = 16'd8; p.data_len = 32'd1;
    p.extra = 3; script.push_back(p);
    p = plain_file(); p.data_len = '0; p.extra = 2; script.push_back(p);
    p = plain_file(); p.has_pre = 1'b1; p.pre_len = 32'd5; p.fmt_len = 32'd19;
    p.chans = 16'd3; p.bits = 16'd24; p.data_len = 32'd9; script.push_back(p);
    p = plain_file(); p.has_pre = 1'b1; p.pre_id = IdData; p.pre_len = 32'd3;
    p.has_mid = 1'b1; p.mid_len = '0; p.bits = 16'd32; script.push_back(p);
    p = plain_file(); p.fmt_len = 32'd12; script.push_back(p);
    p = plain_file(); p.data_len = 32'h8000_0000; p.want = WANT_CODE;
    p.want_err = ERR_NEG_LEN; script.push_back(p);
    p = plain_file(); p.has_pre = 1'b1; p.pre_len = 32'hFFFF_FFFF; p.want = WANT_CODE;
    p.want_err = ERR_NEG_LEN; script.push_back(p);
    p = plain_file(); p.bits = 16'd7; p.want = WANT_CODE; p.want_err = ERR_LOW_BITS;
    script.push_back(p);
    p = plain_file(); p.bits = 16'h8000; p.want = WANT_CODE; p.want_err = ERR_LOW_BITS;
    script.push_back(p);
    p = plain_file(); p.chans = '0; p.want = WANT_CODE; p.want_err = ERR_NO_CHAN;
    script.push_back(p);
    p = plain_file(); p.fmt_id = 32'h4B4E_554A; p.data_len = 32'd4; p.want = WANT_CODE;
    p.want_err = ERR_NO_FMT; script.push_back(p);
    p = plain_file(); p.data_id = 32'h4B4E_554A; p.data_len = 32'd4; p.want = WANT_CODE;
    p.want_err = ERR_NO_DATA; script.push_back(p);
    p = plain_file(); p.cut_at = 5; p.want = WANT_CODE; p.want_err = ERR_NO_FMT;
    script.push_back(p);
    p = plain_file(); p.cut_at = 25; p.want = WANT_CODE; p.want_err = ERR_NO_DATA;
    script.push_back(p);
    p = plain_file(); p.cut_at = 30; p.end_flag = 1'b0; script.push_back(p);
    p = plain_file(); p.cut_at = 47; script.push_back(p);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      set_idling(i % 4);
      play_file(script[i]);
    end

    file_idx   = 0;
    while (items_sent < 1250) begin
      if (file_idx % 5 == 0) set_idling((file_idx / 5) % 4);
      if (file_idx % 29 == 1) hold_asks <= hold_asks + 1;
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          w.data_byte  = 8'($urandom());
          w.file_start = ($urandom_range(0, 7) == 0);
          w.file_end   = ($urandom_range(0, 7) == 0);
          send_byte(w, WANT_MODEL, ERR_NO_FMT);
        end
      end else begin
        play_file(random_file());
      end
      file_idx++;
    end

    in_ch.valid <= 1'b0;
    set_idling(0);
    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results expected, none arrived", $time, pending_results.size());
      fault_count++;
    end
    if (fault_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
